// ===== hdl/tsu_pkg.sv =====
// Shared types, codes and constants for the TOML basic string unescaper.
package tsu_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_OPEN = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_BYTE  = 2'd0;
  localparam logic [1:0] RK_CLOSE = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NEWLINE   = 3'd1;
  localparam logic [2:0] ERR_ESCAPE    = 3'd2;
  localparam logic [2:0] ERR_HEX       = 3'd3;
  localparam logic [2:0] ERR_CODEPOINT = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;
  localparam logic [2:0] ERR_UNTERM    = 3'd6;

  // Characters the decoder looks at
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_UC_U  = 8'h55;

  // Codepoint limits
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] CP_SUR_LO  = 32'h0000_D800;
  localparam logic [31:0] CP_SUR_HI  = 32'h0000_DFFF;
  localparam logic [31:0] CP_1B_MAX  = 32'h0000_007F;
  localparam logic [31:0] CP_2B_MAX  = 32'h0000_07FF;
  localparam logic [31:0] CP_3B_MAX  = 32'h0000_FFFF;

  // Job queue between front and back
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  // One job: the one to four results caused by one input transaction
  typedef struct packed {
    logic [1:0]      rk;      // result kind for every result of the job
    logic [2:0]      err;     // error code, error jobs only
    logic [1:0]      cnt_m1;  // number of results minus one
    logic [3:0][7:0] bytes;   // byte results, index 0 first
  } job_t;

endpackage

// ===== hdl/tsu_front.sv =====
// Front end: tracks the string parse state and turns each transaction into a job.
module tsu_front import tsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_kind,
  input  logic       in_triple_quoted,
  input  logic [7:0] in_char_byte,
  output logic       jq_push,
  output job_t       jq_job,
  input  logic       jq_full
);

  typedef struct packed {
    logic        in_string;
    logic        multiline;
    logic        skip_nl;
    logic        esc;
    logic [3:0]  hex_rem;
    logic [31:0] hex_acc;
    logic [1:0]  held;
  } st_t;

  localparam st_t ST_IDLE = '0;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Codepoint to a UTF-8 job, or a bad codepoint error
  function automatic job_t utf8_job(input logic [31:0] cp);
    job_t j;
    j = '0;
    if (cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) begin
      j.rk  = RK_ERROR;
      j.err = ERR_CODEPOINT;
    end else if (cp <= CP_1B_MAX) begin
      j.bytes[0] = cp[7:0];
    end else if (cp <= CP_2B_MAX) begin
      j.cnt_m1   = 2'd1;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= CP_3B_MAX) begin
      j.cnt_m1   = 2'd2;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      j.cnt_m1   = 2'd3;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

  st_t  st_r, st_nxt;
  job_t job;
  logic job_valid;
  logic accept;

  assign in_full = jq_full;
  assign accept  = in_push && !jq_full;
  assign jq_push = accept && job_valid;
  assign jq_job  = job;

  // Next state and job for the presented transaction
  always_comb begin
    logic [4:0]  hd;
    logic [31:0] acc;
    logic [2:0]  total;
    logic        not_bsl;
    logic [7:0]  c;
    c         = in_char_byte;
    hd        = hex_digit(c);
    acc       = {st_r.hex_acc[27:0], hd[3:0]};
    not_bsl   = (c != CH_BSL);
    total     = {1'b0, st_r.held} + {2'b00, not_bsl};
    st_nxt    = st_r;
    job       = '0;
    job_valid = 1'b0;
    unique case (in_kind)
      KIND_OPEN: begin
        st_nxt           = ST_IDLE;
        st_nxt.in_string = 1'b1;
        st_nxt.multiline = in_triple_quoted;
        st_nxt.skip_nl   = in_triple_quoted;
      end
      KIND_CHAR: begin
        if (st_r.in_string) begin
          st_nxt.skip_nl = 1'b0;
          if (st_r.skip_nl && c == CH_LF) begin
            // newline right after the opener is dropped
          end else if (st_r.hex_rem != 4'd0) begin
            if (!hd[4]) begin
              job_valid = 1'b1;
              job.rk    = RK_ERROR;
              job.err   = ERR_HEX;
              st_nxt    = ST_IDLE;
            end else if (st_r.hex_rem == 4'd1) begin
              job_valid = 1'b1;
              job       = utf8_job(acc);
              st_nxt.hex_rem = 4'd0;
              st_nxt.hex_acc = '0;
              if (job.rk == RK_ERROR) st_nxt = ST_IDLE;
            end else begin
              st_nxt.hex_rem = st_r.hex_rem - 4'd1;
              st_nxt.hex_acc = acc;
            end
          end else if (st_r.esc) begin
            st_nxt.esc = 1'b0;
            job_valid  = 1'b1;
            unique case (c)
              CH_QUOTE: job.bytes[0] = CH_QUOTE;
              CH_BSL:   job.bytes[0] = CH_BSL;
              CH_B:     job.bytes[0] = 8'h08;
              CH_F:     job.bytes[0] = 8'h0C;
              CH_N:     job.bytes[0] = 8'h0A;
              CH_R:     job.bytes[0] = 8'h0D;
              CH_T:     job.bytes[0] = 8'h09;
              CH_LC_U: begin
                job_valid      = 1'b0;
                st_nxt.hex_rem = 4'd4;
                st_nxt.hex_acc = '0;
              end
              CH_UC_U: begin
                job_valid      = 1'b0;
                st_nxt.hex_rem = 4'd8;
                st_nxt.hex_acc = '0;
              end
              default: begin
                job.rk  = RK_ERROR;
                job.err = ERR_ESCAPE;
                st_nxt  = ST_IDLE;
              end
            endcase
          end else if (st_r.multiline) begin
            if (c == CH_QUOTE) begin
              if (st_r.held == 2'd2) begin
                // third quote closes the string
                job_valid = 1'b1;
                job.rk    = RK_CLOSE;
                st_nxt    = ST_IDLE;
              end else begin
                st_nxt.held = st_r.held + 2'd1;
              end
            end else begin
              // held quotes go out first, then the character unless it is a backslash
              st_nxt.held  = 2'd0;
              st_nxt.esc   = !not_bsl;
              job_valid    = (total != 3'd0);
              job.cnt_m1   = 2'(total - 3'd1);
              job.bytes[0] = (st_r.held >= 2'd1) ? CH_QUOTE : c;
              job.bytes[1] = (st_r.held >= 2'd2) ? CH_QUOTE : c;
              job.bytes[2] = c;
            end
          end else begin
            if (c == CH_QUOTE) begin
              job_valid = 1'b1;
              job.rk    = RK_CLOSE;
              st_nxt    = ST_IDLE;
            end else if (c == CH_LF || c == CH_CR) begin
              job_valid = 1'b1;
              job.rk    = RK_ERROR;
              job.err   = ERR_NEWLINE;
              st_nxt    = ST_IDLE;
            end else if (!not_bsl) begin
              st_nxt.esc = 1'b1;
            end else begin
              job_valid    = 1'b1;
              job.bytes[0] = c;
            end
          end
        end
      end
      KIND_END: begin
        if (st_r.in_string) begin
          job_valid = 1'b1;
          job.rk    = RK_ERROR;
          job.err   = (st_r.esc || st_r.hex_rem != 4'd0) ? ERR_TRUNCATED : ERR_UNTERM;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        // unused kind: no effect
      end
    endcase
  end

  // Parse state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== hdl/tsu_jobq.sv =====
// Short job queue that decouples the front end from the result sequencer.
module tsu_jobq import tsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == JQ_CW'(JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + JQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + JQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + JQ_CW'(do_push) - JQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/tsu_back.sv =====
// Back end: walks each job one result per cycle into the output register while that register is free or being popped.
module tsu_back import tsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       jq_head,
  input  logic       jq_empty,
  output logic       jq_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [1:0] rk_r;
  logic [7:0] byte_r;
  logic [2:0] err_r;
  logic       last_r;
  logic       adv, take, fin;

  // Output slot frees when empty or when its result is popped
  assign adv    = !vld_r || out_pop;
  assign take   = adv && !jq_empty;
  assign fin    = (idx_r == jq_head.cnt_m1);
  assign jq_pop = take && fin;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (take) begin
      vld_nxt = 1'b1;
      idx_nxt = fin ? 2'd0 : idx_r + 2'd1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      rk_r   <= jq_head.rk;
      byte_r <= jq_head.bytes[idx_r];
      err_r  <= jq_head.err;
      last_r <= fin;
    end
  end

  assign out_empty       = !vld_r;
  assign out_result_kind = rk_r;
  assign out_byte        = byte_r;
  assign out_error_code  = err_r;
  assign out_last        = last_r;

endmodule

// ===== hdl/toml_string_unescape_top.sv =====
// Top level of the TOML basic string unescaper.
// One input transaction (open, character or end) is taken per clock while
// in_full is low; in_full rises only when the four-entry job queue between
// the decoder and the result sequencer is full. Each transaction yields zero
// to four results (up to four UTF-8 bytes from a hex escape, up to three
// for flushed quotes plus a character), and results leave at one per clock
// through a single output register while out_pop takes them. A result passes
// through the job queue and then the output register. out_last marks the
// final result of each transaction.
module toml_string_unescape_top import tsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_kind,
  input  logic       in_triple_quoted,
  input  logic [7:0] in_char_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_in, jq_head;

  tsu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_triple_quoted (in_triple_quoted),
    .in_char_byte     (in_char_byte),
    .jq_push          (jq_push),
    .jq_job           (jq_in),
    .jq_full          (jq_full)
  );

  tsu_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in),
    .full     (jq_full),
    .pop      (jq_pop),
    .head     (jq_head),
    .empty    (jq_empty)
  );

  tsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jq_head         (jq_head),
    .jq_empty        (jq_empty),
    .jq_pop          (jq_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

endmodule

// ===== hdl/tsu_checker.sv =====
// Port-level checks for the unescaper top level, with their bind.
module tsu_checker import tsu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_byte,
  input logic [2:0] out_error_code,
  input logic       out_last
);

  // Nothing to read right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Close and error results end their transaction's results
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind != RK_BYTE) |-> out_last)
    else $error("close or error result not marked last");

  // Byte results carry no error, other results carry no byte
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_result_kind == RK_BYTE && out_error_code == ERR_NONE) ||
                    (out_result_kind == RK_CLOSE && out_error_code == ERR_NONE &&
                     out_byte == 8'h00) ||
                    (out_result_kind == RK_ERROR && out_error_code != ERR_NONE &&
                     out_byte == 8'h00)))
    else $error("inconsistent result fields");

  // A waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_kind) &&
                                  $stable(out_byte) && $stable(out_last)))
    else $error("waiting result changed before pop");

endmodule

bind toml_string_unescape_top tsu_checker u_tsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_result_kind (out_result_kind),
  .out_byte        (out_byte),
  .out_error_code  (out_error_code),
  .out_last        (out_last)
);
